/* hw/rtl/srh_pkg.sv */
// shared constants and types for the sequence reorder heap
`default_nettype none
package srh_pkg;
    localparam int HeapDepth = 64;
    localparam int AddrW = $clog2(HeapDepth);
    localparam int CntW = $clog2(HeapDepth + 1);
    localparam int EntW = 32 + 34 + 40;

    localparam logic [1:0] StInOrder = 2'd0;
    localparam logic [1:0] StFlush = 2'd1;
    localparam logic [1:0] StDropped = 2'd2;

    typedef struct packed {
        logic [31:0] key;
        logic [33:0] place;
        logic [39:0] body;
    } t_entry;
endpackage
`default_nettype wire

/* hw/rtl/sequence_reorder_heap.sv */
// reorder buffer holding out-of-order tiles in a min-heap memory
//  channel | signals                              | direction
//  in      | i_valid o_ready + input fields       | upstream to block
//  out     | o_valid i_out_ready + result fields  | block to downstream consumer
// one item at a time; a push places the new entry at the tail and sifts it up, reading each parent
// each release moves the tail entry to the root and sifts it down, reading left then right child (one memory read port)
// reset clears count, expected number and total; the heap memory is not cleared
// a waiting result holds the sequencer until it is taken
`default_nettype none
module sequence_reorder_heap
    import srh_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_ready,
    input  wire  [0:0]  i_func,
    input  wire  [31:0] i_sequence_req,
    input  wire  [3:0]  i_zoom,
    input  wire  [14:0] i_tile_x,
    input  wire  [14:0] i_tile_y,
    input  wire  [15:0] i_payload_handle,
    input  wire  [23:0] i_tile_size,
    output logic        o_valid,
    input  wire         i_out_ready,
    output logic [1:0]  o_status,
    output logic [31:0] o_out_sequence,
    output logic [3:0]  o_out_zoom,
    output logic [14:0] o_out_x,
    output logic [14:0] o_out_y,
    output logic [15:0] o_out_handle,
    output logic [23:0] o_out_size,
    output logic        o_counted,
    output logic [31:0] o_written_total,
    output logic        o_last
);
    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_UPRD  = 10'b0000000010,
        S_UPCMP = 10'b0000000100,
        S_HEAD  = 10'b0000001000,
        S_HEADW = 10'b0000010000,
        S_TAIL  = 10'b0000100000,
        S_DNL   = 10'b0001000000,
        S_DNR   = 10'b0010000000,
        S_DNCMP = 10'b0100000000,
        S_EMIT  = 10'b1000000000
    } t_state;

    t_entry r_mem [HeapDepth];
    t_entry r_rd;
    logic [AddrW-1:0] n_ra;
    logic n_we;
    logic [AddrW-1:0] n_wa;
    t_entry n_wd;

    t_state r_st, n_st;
    logic [CntW-1:0] r_cnt, n_cnt;
    logic [31:0] r_exp, n_exp, r_tot, n_tot;
    logic r_flush, n_flush;
    t_entry r_cur, n_cur, r_lc, n_lc, r_out, n_out;
    logic [AddrW-1:0] r_pos, n_pos;
    logic r_hasl, n_hasl;
    logic r_ov, n_ov;
    logic [1:0] r_ost, n_ost;
    logic r_ocnt, n_ocnt, r_olast, n_olast;
    logic [31:0] r_otot, n_otot;

    logic [CntW:0] l_idx, r_idx;
    logic [AddrW-1:0] par;
    logic nz;
    logic [31:0] hkey;

    always_ff @(posedge i_clk) begin
        if (n_we) r_mem[n_wa] <= n_wd;
        r_rd <= r_mem[n_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_cnt <= '0;
            r_exp <= '0;
            r_tot <= '0;
            r_ov <= 1'b0;
        end else begin
            r_st <= n_st;
            r_cnt <= n_cnt;
            r_exp <= n_exp;
            r_tot <= n_tot;
            r_ov <= n_ov;
        end
        r_flush <= n_flush;
        r_cur <= n_cur;
        r_lc <= n_lc;
        r_out <= n_out;
        r_pos <= n_pos;
        r_hasl <= n_hasl;
        r_ost <= n_ost;
        r_ocnt <= n_ocnt;
        r_olast <= n_olast;
        r_otot <= n_otot;
    end

    always_comb begin
        n_st = r_st; n_cnt = r_cnt; n_exp = r_exp; n_tot = r_tot;
        n_flush = r_flush; n_cur = r_cur; n_lc = r_lc; n_out = r_out;
        n_pos = r_pos; n_hasl = r_hasl; n_ov = r_ov; n_ost = r_ost;
        n_ocnt = r_ocnt; n_olast = r_olast; n_otot = r_otot;
        n_ra = '0; n_we = 1'b0; n_wa = r_pos; n_wd = r_cur;
        o_ready = 1'b0;
        par = AddrW'((r_pos - 1'b1) >> 1);
        l_idx = {r_pos, 1'b1} + (CntW+1)'(0);
        r_idx = l_idx + 1'b1;
        nz = r_out.body[23:0] != '0;
        // head as it stands after the last sift-down write
        hkey = (r_pos == '0) ? r_cur.key : r_rd.key;
        if (r_ov && i_out_ready) n_ov = 1'b0;
        unique case (r_st)
            S_IDLE: begin
                o_ready = !r_ov;
                if (i_valid && !r_ov) begin
                    n_flush = i_func[0];
                    n_cur = '{key: i_sequence_req,
                              place: {i_zoom, i_tile_x, i_tile_y},
                              body: {i_payload_handle, i_tile_size}};
                    if (i_func[0]) begin
                        n_st = (r_cnt != '0) ? S_HEAD : S_IDLE;
                    end else if (r_cnt >= CntW'(HeapDepth)) begin
                        n_ov = 1'b1; n_ost = StDropped; n_ocnt = 1'b0;
                        n_olast = 1'b1; n_otot = r_tot;
                        n_out = n_cur;
                    end else begin
                        n_pos = AddrW'(r_cnt);
                        n_cnt = r_cnt + 1'b1;
                        n_st = S_UPRD;
                    end
                end
            end
            S_UPRD: begin
                if (r_pos == '0) begin
                    n_we = 1'b1; n_st = S_HEAD;
                end else begin
                    n_ra = par; n_st = S_UPCMP;
                end
            end
            S_UPCMP: begin
                if (r_cur.key < r_rd.key) begin
                    n_we = 1'b1; n_wd = r_rd; n_pos = par; n_st = S_UPRD;
                end else begin
                    n_we = 1'b1; n_st = S_HEAD;
                end
            end
            S_HEAD: begin
                n_ra = '0;
                n_st = S_HEADW;
                if (r_cnt == '0) n_st = S_IDLE;
            end
            S_HEADW: begin
                if (r_flush || r_rd.key == r_exp) begin
                    if (!r_ov) begin
                        n_out = r_rd;
                        n_cnt = r_cnt - 1'b1;
                        if (!r_flush) n_exp = r_exp + 1'b1;
                        n_ra = AddrW'(r_cnt - 1'b1);
                        n_st = S_TAIL;
                    end else n_ra = '0;
                end else n_st = S_IDLE;
            end
            S_TAIL: begin
                n_cur = r_rd; n_pos = '0;
                n_st = (r_cnt == '0) ? S_EMIT : S_DNL;
            end
            S_DNL: begin
                if (l_idx < (CntW+1)'(r_cnt)) begin
                    n_ra = AddrW'(l_idx); n_st = S_DNR;
                end else begin
                    n_we = 1'b1; n_st = S_EMIT;
                end
            end
            S_DNR: begin
                n_lc = r_rd;
                n_hasl = r_idx < (CntW+1)'(r_cnt);
                n_ra = AddrW'(r_idx);
                n_st = S_DNCMP;
            end
            S_DNCMP: begin
                if (r_hasl && r_rd.key < r_lc.key && r_rd.key < r_cur.key) begin
                    n_we = 1'b1; n_wd = r_rd; n_pos = AddrW'(r_idx); n_st = S_DNL;
                end else if (r_lc.key < r_cur.key) begin
                    n_we = 1'b1; n_wd = r_lc; n_pos = AddrW'(l_idx); n_st = S_DNL;
                end else begin
                    n_we = 1'b1; n_st = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!r_ov) begin
                    n_ov = 1'b1;
                    n_ost = r_flush ? StFlush : StInOrder;
                    n_ocnt = nz;
                    n_tot = (nz && r_tot != '1) ? r_tot + 1'b1 : r_tot;
                    n_otot = n_tot;
                    // last unless the next head also leaves
                    n_olast = !(r_cnt != '0 && (r_flush || hkey == r_exp));
                    n_ra = '0;
                    n_st = S_HEADW;
                    if (r_cnt == '0) n_st = S_IDLE;
                end
            end
            default: n_st = S_IDLE;
        endcase
    end

    assign o_valid = r_ov;
    assign o_status = r_ost;
    assign o_out_sequence = r_out.key;
    assign o_out_zoom = r_out.place[33:30];
    assign o_out_x = r_out.place[29:15];
    assign o_out_y = r_out.place[14:0];
    assign o_out_handle = r_out.body[39:24];
    assign o_out_size = r_out.body[23:0];
    assign o_counted = r_ocnt;
    assign o_written_total = r_otot;
    assign o_last = r_olast;
endmodule
`default_nettype wire
